@@ design/rtcl_pkg.sv @@
// Shared constants for the row to chunk locator: register indexes, opcodes and
// the fixed field widths of the stream items. No dependencies.
`default_nettype none
package rtcl_pkg;

    localparam int unsigned ROW_W    = 31;
    localparam int unsigned ENTRY_W  = 10;
    localparam int unsigned TARGET_W = 32;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DIV_STEPS = 31;

    localparam int unsigned S_TDATA_W = 104;
    localparam int unsigned M_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_UNIFORM_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ROWS   = 2'd3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

endpackage
`default_nettype wire

@@ design/row_to_chunk_locator.sv @@
// Top level of the row to chunk locator: a lockstep pipeline that carries a
// restoring divider and a staged binary search side by side.
// Depends on rtcl_pkg.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: op; tdata: entry, first, last, target
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: found; tdata: chunk_num, row_offset
// cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// Every item passes through every stage before the output register; one item
// enters per cycle unless a held result stalls the pipeline.
// The depth is set by the 31 divider stages and by two stages per search step,
// each step owning its own copy of the range table that writes update in order.
// Reset clears the valid bits and the configuration registers; the table stays undefined.
// A held result stalls the whole pipeline, so nothing is lost or repeated.
`default_nettype none
module row_to_chunk_locator #(
    parameter int unsigned MAX_CHUNKS = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: entry[9:0], first_row[40:10], last_row[71:41], target_row[103:72]
    input  wire logic [rtcl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // tuser: op
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: chunk_num[9:0], row_offset[40:10], zero fill above
    output logic [rtcl_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    // tuser: found
    output logic                                    m_axis_tuser,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [rtcl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rtcl_pkg::ROW_W-1:0]         i_cfg_data
);

    localparam int unsigned IW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int unsigned SW   = IW + 2;
    localparam int unsigned NS   = $clog2(MAX_CHUNKS + 1);
    localparam int unsigned SRCH = 2 * NS;
    localparam int unsigned NSTG = ((SRCH > rtcl_pkg::DIV_STEPS) ? SRCH
                                    : rtcl_pkg::DIV_STEPS) + 1;
    localparam int unsigned RW   = rtcl_pkg::ROW_W;

    typedef struct packed {
        logic                      valid;
        logic                      op;
        logic [rtcl_pkg::ENTRY_W-1:0] entry;
        logic [RW-1:0]             first;
        logic [RW-1:0]             last;
        logic [RW-1:0]             row;
        logic                      ok;
        logic [RW:0]               rem;
        logic [RW-1:0]             quo;
        logic signed [SW-1:0]      lo;
        logic signed [SW-1:0]      hi;
        logic [IW-1:0]             mid;
        logic                      sfound;
        logic [IW-1:0]             sidx;
        logic [RW-1:0]             soff;
    } t_stage;

    logic          r_uniform;
    logic [RW-1:0] r_batch;
    logic [rtcl_pkg::COUNT_W-1:0] r_count;
    logic [RW-1:0] r_total;

    t_stage r_st [NSTG];
    t_stage n_st [NSTG];
    logic [RW-1:0] r_rd_f [NS];
    logic [RW-1:0] r_rd_l [NS];

    logic          w_en;
    logic [31:0]   w_cnt;
    logic          w_uni;
    logic          r_ov;
    logic          r_ofound;
    logic [rtcl_pkg::ENTRY_W-1:0] r_oidx;
    logic [RW-1:0] r_ooff;

    assign o_cfg_ready   = 1'b1;
    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_cnt = (32'(r_count) > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS) : 32'(r_count);
    assign w_uni = r_uniform && (r_batch != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uniform <= 1'b0;
            r_batch   <= '0;
            r_count   <= '0;
            r_total   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rtcl_pkg::REG_UNIFORM_MODE: r_uniform <= i_cfg_data[0];
                rtcl_pkg::REG_BATCH_SIZE:   r_batch   <= i_cfg_data;
                rtcl_pkg::REG_CHUNK_COUNT:  r_count   <= i_cfg_data[rtcl_pkg::COUNT_W-1:0];
                rtcl_pkg::REG_TOTAL_ROWS:   r_total   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_st[0]        = '0;
        n_st[0].valid  = s_axis_tvalid;
        n_st[0].op     = s_axis_tuser;
        n_st[0].entry  = s_axis_tdata[9:0];
        n_st[0].first  = s_axis_tdata[40:10];
        n_st[0].last   = s_axis_tdata[71:41];
        n_st[0].row    = s_axis_tdata[102:72];
        n_st[0].ok     = !s_axis_tdata[103] && (s_axis_tdata[102:72] < r_total);
        n_st[0].hi     = SW'(w_cnt) - SW'(1);
    end

    genvar gi;
    generate
        for (gi = 1; gi < NSTG; gi++) begin : g_stage
            localparam int unsigned DIVB = (gi <= 31) ? 31 - gi : 0;
            localparam int unsigned KB   = (gi >= 2) ? (gi - 2) / 2 : 0;
            localparam bit IS_DIV = (gi <= 31);
            localparam bit IS_A   = (gi % 2 == 1) && ((gi - 1) / 2 < NS);
            localparam bit IS_B   = (gi >= 2) && (gi % 2 == 0) && ((gi - 2) / 2 < NS);
            logic [RW:0]          w_rem2;
            logic signed [SW:0]   w_sum;
            logic                 w_act;
            always_comb begin
                n_st[gi] = r_st[gi-1];
                w_rem2   = {r_st[gi-1].rem[RW-1:0], r_st[gi-1].row[DIVB]};
                w_sum    = {r_st[gi-1].lo[SW-1], r_st[gi-1].lo}
                           + {r_st[gi-1].hi[SW-1], r_st[gi-1].hi};
                w_act    = (r_st[gi-1].lo <= r_st[gi-1].hi) && !r_st[gi-1].sfound;
                if (IS_DIV) begin
                    if (w_rem2 >= {1'b0, r_batch}) begin
                        n_st[gi].rem = w_rem2 - {1'b0, r_batch};
                        n_st[gi].quo = {r_st[gi-1].quo[RW-2:0], 1'b1};
                    end else begin
                        n_st[gi].rem = w_rem2;
                        n_st[gi].quo = {r_st[gi-1].quo[RW-2:0], 1'b0};
                    end
                end
                if (IS_A) begin
                    n_st[gi].mid = w_sum[IW:1];
                end
                if (IS_B && w_act) begin
                    if (r_st[gi-1].row >= r_rd_f[KB] && r_st[gi-1].row <= r_rd_l[KB]) begin
                        n_st[gi].sfound = 1'b1;
                        n_st[gi].sidx   = r_st[gi-1].mid;
                        n_st[gi].soff   = r_st[gi-1].row - r_rd_f[KB];
                    end else if (r_st[gi-1].row < r_rd_f[KB]) begin
                        n_st[gi].hi = $signed({2'b00, r_st[gi-1].mid}) - SW'(1);
                    end else begin
                        n_st[gi].lo = $signed({2'b00, r_st[gi-1].mid}) + SW'(1);
                    end
                end
            end
        end

        for (gi = 0; gi < NS; gi++) begin : g_table
            logic [RW-1:0] r_mem_f [MAX_CHUNKS];
            logic [RW-1:0] r_mem_l [MAX_CHUNKS];
            logic [31:0]   w_ent;
            logic          w_wr;
            logic [IW:0]   w_mid;
            assign w_ent = 32'(r_st[2*gi].entry);
            assign w_wr  = r_st[2*gi].valid && (r_st[2*gi].op == rtcl_pkg::OP_WRITE)
                           && (w_ent < 32'(MAX_CHUNKS));
            assign w_mid = n_st[2*gi+1].mid[IW-1:0] + (IW+1)'(0);
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    if (w_wr) begin
                        r_mem_f[w_ent[IW-1:0]] <= r_st[2*gi].first;
                        r_mem_l[w_ent[IW-1:0]] <= r_st[2*gi].last;
                    end
                    r_rd_f[gi] <= r_mem_f[w_mid[IW-1:0]];
                    r_rd_l[gi] <= r_mem_l[w_mid[IW-1:0]];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) begin
                r_st[i].valid <= 1'b0;
            end
        end else if (w_en) begin
            for (int i = 0; i < NSTG; i++) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    t_stage w_last;
    logic   w_found;
    assign w_last  = r_st[NSTG-1];
    assign w_found = w_last.ok && (w_uni ? ({1'b0, w_last.quo} < w_cnt) : w_last.sfound);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_last.valid && (w_last.op == rtcl_pkg::OP_LOOKUP);
        end
        if (w_en) begin
            r_ofound <= w_found;
            if (!w_found) begin
                r_oidx <= '0;
                r_ooff <= '0;
            end else if (w_uni) begin
                r_oidx <= w_last.quo[rtcl_pkg::ENTRY_W-1:0];
                r_ooff <= w_last.rem[RW-1:0];
            end else begin
                r_oidx <= rtcl_pkg::ENTRY_W'({{32{1'b0}}, w_last.sidx});
                r_ooff <= w_last.soff;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_ofound;
    assign m_axis_tdata  = {7'd0, r_ooff, r_oidx};

endmodule
`default_nettype wire
